### rtl/core/brle_pkg.sv
// shared types and constants for the bounded run-length encoder
`default_nettype none

package brle_pkg;

	localparam int unsigned COORD_W = 16;
	localparam int unsigned TAG_W   = 8;
	localparam int unsigned CFG_IDX_W = 3;

	// register indexes on the configuration channel
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_WIDTH   = 3'd0,
		CFG_BLOCK_WIDTH = 3'd1,
		CFG_LAYER_Z     = 3'd2,
		CFG_FIRST_ROW   = 3'd3,
		CFG_ROW_COUNT   = 3'd4
	} cfg_index_t;

	localparam logic [COORD_W-1:0] RESET_ROW_WIDTH   = 16'd64;
	localparam logic [COORD_W-1:0] RESET_BLOCK_WIDTH = 16'd8;
	localparam logic [COORD_W-1:0] RESET_LAYER_Z     = 16'd0;
	localparam logic [COORD_W-1:0] RESET_FIRST_ROW   = 16'd0;
	localparam logic [COORD_W-1:0] RESET_ROW_COUNT   = 16'd64;
	localparam logic [COORD_W-1:0] ROWS_DONE_MAX     = 16'hFFFF;

	typedef struct packed {
		logic [COORD_W-1:0] row_width;
		logic [COORD_W-1:0] block_width;
		logic [COORD_W-1:0] layer_z;
		logic [COORD_W-1:0] first_row;
		logic [COORD_W-1:0] row_count;
	} cfg_t;

	typedef struct packed {
		logic               last;
		logic [TAG_W-1:0]   tag;
		logic [COORD_W-1:0] length;
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} result_t;

	// up to two results from one byte, the earlier one in first
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

`default_nettype wire

### rtl/core/block_bounded_run_length_encoder_unit.sv
// top level of the bounded run-length encoder: registers, input stage, core and queue
`default_nettype none

// Bounded run-length encoder. Tag bytes of one map layer stream in row-major
// order on the s_axis channel, one byte per request. Each row is cut into runs
// of equal tags; a run also ends at every multiple of block_width and at the
// row end, and bytes after row_count rows are dropped without result. Each
// run leaves on m_axis as {run_tag, run_length, run_z, run_y, run_x}, with
// tlast high on the final result that a byte causes (a byte may close the
// previous run and finish its own one-byte run, giving two results). A byte
// is taken every cycle while the queue has room; it is held in the input
// register, is encoded in a single pass against the run state, and its
// results enter a FIFO_DEPTH-entry queue. The output port moves one result
// per cycle while m_axis_tready is high, so bytes with two results stall
// the input once the queue has filled. Configuration writes take effect at
// once and are meant for an idle block; cfg_ready is always high and
// unknown indexes are ignored.
module block_bounded_run_length_encoder_unit #(
	parameter int unsigned FIFO_DEPTH = 4 // at least 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	// tag byte requests
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // tag_byte[7:0]
	// run results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [71:0]      m_axis_tdata,  // run_x[15:0], run_y[31:16], run_z[47:32],
	                                        // run_length[63:48], run_tag[71:64]
	output logic             m_axis_tlast   // last_result
);
	import brle_pkg::*;

	cfg_t             cfg_q;
	logic             valid_s1;
	logic [TAG_W-1:0] tag_s1;
	logic             advance;
	logic             room;
	push_t            push;
	result_t          head;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_width   <= RESET_ROW_WIDTH;
			cfg_q.block_width <= RESET_BLOCK_WIDTH;
			cfg_q.layer_z     <= RESET_LAYER_Z;
			cfg_q.first_row   <= RESET_FIRST_ROW;
			cfg_q.row_count   <= RESET_ROW_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ROW_WIDTH:   cfg_q.row_width   <= cfg_data;
				CFG_BLOCK_WIDTH: cfg_q.block_width <= cfg_data;
				CFG_LAYER_Z:     cfg_q.layer_z     <= cfg_data;
				CFG_FIRST_ROW:   cfg_q.first_row   <= cfg_data;
				CFG_ROW_COUNT:   cfg_q.row_count   <= cfg_data;
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	// input stage: the held byte moves on once the queue has space for two results
	assign advance       = valid_s1 && room;
	assign s_axis_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			tag_s1 <= s_axis_tdata;
		end
	end

	// run tracking and result forming
	brle_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.advance (advance),
		.tag     (tag_s1),
		.push    (push)
	);

	// result queue decouples the output handshake from the encoder
	brle_outq #(
		.DEPTH (FIFO_DEPTH)
	) u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (head)
	);

	// output packing, run_x in the low bits
	assign m_axis_tdata = {head.tag, head.length, head.z, head.y, head.x};
	assign m_axis_tlast = head.last;

endmodule

`default_nettype wire

### rtl/core/brle_core.sv
// run tracking state and the per-byte encode logic
`default_nettype none

module brle_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire brle_pkg::cfg_t   cfg,
	input  wire logic             advance,
	input  wire logic [7:0]       tag,
	output brle_pkg::push_t       push
);
	import brle_pkg::*;

	logic [TAG_W-1:0]   open_tag_q;
	logic [COORD_W-1:0] open_start_q;
	logic [COORD_W-1:0] open_length_q;
	logic               run_open_q;
	logic [COORD_W-1:0] column_q;
	logic [COORD_W-1:0] block_offset_q;
	logic [COORD_W-1:0] rows_done_q;

	logic [COORD_W-1:0] rw_eff;
	logic [COORD_W-1:0] bw_eff;
	logic [COORD_W:0]   next_col;
	logic [COORD_W:0]   next_blk;
	logic               active;
	logic               cont;
	logic               row_end;
	logic               blk_end;
	logic               emit_prev;
	logic               emit_own;
	logic [COORD_W-1:0] start_n;
	logic [COORD_W-1:0] length_n;
	logic [COORD_W-1:0] run_y;
	result_t            res_prev;
	result_t            res_own;

	always_comb begin
		rw_eff   = (cfg.row_width == '0) ? COORD_W'(1) : cfg.row_width;
		bw_eff   = (cfg.block_width == '0) ? COORD_W'(1) : cfg.block_width;
		next_col = {1'b0, column_q} + (COORD_W+1)'(1);
		next_blk = {1'b0, block_offset_q} + (COORD_W+1)'(1);
		active   = rows_done_q < cfg.row_count;
		cont     = run_open_q && (tag == open_tag_q);
		row_end  = next_col >= {1'b0, rw_eff};
		blk_end  = !row_end && (next_blk >= {1'b0, bw_eff});
		start_n  = cont ? open_start_q : column_q;
		length_n = cont ? (open_length_q + COORD_W'(1)) : COORD_W'(1);
		run_y    = cfg.first_row + rows_done_q;

		emit_prev = advance && active && run_open_q && !cont;
		emit_own  = advance && active && (row_end || blk_end);

		res_prev.x      = open_start_q;
		res_prev.y      = run_y;
		res_prev.z      = cfg.layer_z;
		res_prev.length = open_length_q;
		res_prev.tag    = open_tag_q;
		res_prev.last   = !emit_own;

		res_own.x      = start_n;
		res_own.y      = run_y;
		res_own.z      = cfg.layer_z;
		res_own.length = length_n;
		res_own.tag    = tag;
		res_own.last   = 1'b1;

		push.count  = {1'b0, emit_prev} + {1'b0, emit_own};
		push.first  = emit_prev ? res_prev : res_own;
		push.second = res_own;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_tag_q     <= '0;
			open_start_q   <= '0;
			open_length_q  <= '0;
			run_open_q     <= 1'b0;
			column_q       <= '0;
			block_offset_q <= '0;
			rows_done_q    <= '0;
		end else if (advance && active) begin
			open_tag_q    <= tag;
			open_start_q  <= start_n;
			open_length_q <= length_n;
			run_open_q    <= !(row_end || blk_end);
			if (row_end) begin
				column_q       <= '0;
				block_offset_q <= '0;
				if (rows_done_q != ROWS_DONE_MAX) begin
					rows_done_q <= rows_done_q + COORD_W'(1);
				end
			end else begin
				column_q <= next_col[COORD_W-1:0];
				if (blk_end) begin
					block_offset_q <= '0;
				end else begin
					block_offset_q <= next_blk[COORD_W-1:0];
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/brle_outq.sv
// small result queue, takes up to two results a cycle, gives one while out_ready is high
`default_nettype none

module brle_outq #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire brle_pkg::push_t   push,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output brle_pkg::result_t      out_data
);
	import brle_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	result_t        mem_q [DEPTH];
	logic [PW-1:0]  rd_ptr_q;
	logic [PW-1:0]  wr_ptr_q;
	logic [CW-1:0]  count_q;
	logic [PW-1:0]  wr_ptr_1;
	logic [PW-1:0]  wr_ptr_2;
	logic [PW-1:0]  rd_ptr_1;
	logic           pop;

	always_comb begin
		wr_ptr_1  = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : (wr_ptr_q + PW'(1));
		wr_ptr_2  = (wr_ptr_1 == PW'(DEPTH - 1)) ? '0 : (wr_ptr_1 + PW'(1));
		rd_ptr_1  = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : (rd_ptr_q + PW'(1));
		out_valid = count_q != '0;
		pop       = out_valid && out_ready;
		out_data  = mem_q[rd_ptr_q];
		// space for two results after this cycle's pop
		room = (count_q <= CW'(DEPTH - 2)) || (pop && (count_q == CW'(DEPTH - 1)));
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_1] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_1;
			end
			unique case (push.count)
				2'd1:    wr_ptr_q <= wr_ptr_1;
				2'd2:    wr_ptr_q <= wr_ptr_2;
				default: wr_ptr_q <= wr_ptr_q;
			endcase
			count_q <= count_q + CW'(push.count) - CW'(pop);
		end
	end

endmodule

`default_nettype wire

### rtl/core/brle_checker.sv
// port-level checks for the bounded run-length encoder, bound to the top level
`default_nettype none

module brle_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cfg_valid,
	input wire logic        cfg_ready,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [71:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	// runs are never empty
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[63:48] != 16'd0)
		else $error("zero run length");

	// the closing result of a pair is queued together with the first one
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
		else $error("second result of a byte missing");

	// input only stalls while results are waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid)
		else $error("input stalled with empty output");

	// configuration is always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind block_bounded_run_length_encoder_unit brle_checker u_brle_checker (.*);

`default_nettype wire

### bench/tb.sv
// self-checking bench for the bounded run-length encoder unit
`timescale 1ns / 100ps

import brle_pkg::*;

// one run as it leaves on m_axis_tdata, run_x in the lowest bits
typedef struct packed {
	logic [TAG_W-1:0]   tag;
	logic [COORD_W-1:0] length;
	logic [COORD_W-1:0] z;
	logic [COORD_W-1:0] y;
	logic [COORD_W-1:0] x;
} run_word_t;

typedef struct packed {
	logic      last;
	run_word_t word;
} run_rec_t;

// runs predicted from accepted tag bytes, checked against the results in order
class run_ledger;
	logic [COORD_W-1:0] row_width, block_width, layer_z, first_row, row_count;
	logic [TAG_W-1:0]   open_tag;
	logic [COORD_W-1:0] open_start, open_length, column, block_offset, rows_done;
	bit                 run_open;
	run_rec_t           expected_runs[$];
	run_rec_t           fresh[$];
	int                 mismatches;

	function new();
		row_width    = RESET_ROW_WIDTH;
		block_width  = RESET_BLOCK_WIDTH;
		layer_z      = RESET_LAYER_Z;
		first_row    = RESET_FIRST_ROW;
		row_count    = RESET_ROW_COUNT;
		open_tag     = '0;
		open_start   = '0;
		open_length  = '0;
		column       = '0;
		block_offset = '0;
		rows_done    = '0;
		run_open     = 1'b0;
		mismatches   = 0;
	endfunction

	function void configure(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] value);
		case (idx)
			CFG_ROW_WIDTH: begin
				row_width = value;
			end
			CFG_BLOCK_WIDTH: begin
				block_width = value;
			end
			CFG_LAYER_Z: begin
				layer_z = value;
			end
			CFG_FIRST_ROW: begin
				first_row = value;
			end
			CFG_ROW_COUNT: begin
				row_count = value;
			end
			default: begin
			end
		endcase
	endfunction

	function void close_run();
		run_rec_t r;
		r.last        = 1'b0;
		r.word.x      = open_start;
		r.word.y      = first_row + rows_done;
		r.word.z      = layer_z;
		r.word.length = open_length;
		r.word.tag    = open_tag;
		fresh.push_back(r);
		run_open = 1'b0;
	endfunction

	// returns 0 when the byte is dropped because all rows are done
	function bit note_tag(logic [TAG_W-1:0] tag);
		int unsigned rw, bw, next_col, next_blk;
		rw = (row_width == 0) ? 1 : row_width;
		bw = (block_width == 0) ? 1 : block_width;
		if (rows_done >= row_count)
			return 1'b0;
		fresh.delete();
		if (run_open && tag == open_tag) begin
			open_length = open_length + 1'b1;
		end else begin
			if (run_open)
				close_run();
			open_tag    = tag;
			open_start  = column;
			open_length = 1;
			run_open    = 1'b1;
		end
		next_col = column + 1;
		next_blk = block_offset + 1;
		// row end wins over block end; widths may have shrunk mid-row, hence >=
		if (next_col >= rw) begin
			close_run();
			column       = '0;
			block_offset = '0;
			if (rows_done != ROWS_DONE_MAX)
				rows_done = rows_done + 1'b1;
		end else begin
			column = next_col[COORD_W-1:0];
			if (next_blk >= bw) begin
				close_run();
				block_offset = '0;
			end else begin
				block_offset = next_blk[COORD_W-1:0];
			end
		end
		if (fresh.size() > 0)
			fresh[fresh.size()-1].last = 1'b1;
		foreach (fresh[i])
			expected_runs.push_back(fresh[i]);
		return 1'b1;
	endfunction

	task report_mismatch(string msg);
		$display("tb: mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task compare_field(string name, int unsigned got, int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task check_run(logic [71:0] data, logic last);
		run_word_t got;
		run_rec_t  want;
		got = data;
		if (expected_runs.size() == 0) begin
			report_mismatch($sformatf("unexpected run x=%0d y=%0d tag=%0d",
				got.x, got.y, got.tag));
			return;
		end
		want = expected_runs.pop_front();
		if ($isunknown({data, last})) begin
			report_mismatch("run result carries unknown bits");
			return;
		end
		compare_field("run_x", got.x, want.word.x);
		compare_field("run_y", got.y, want.word.y);
		compare_field("run_z", got.z, want.word.z);
		compare_field("run_length", got.length, want.word.length);
		compare_field("run_tag", got.tag, want.word.tag);
		compare_field("last_result", last, want.last);
	endtask
endclass

module tb;

	localparam int unsigned SETTLE_CYCLES = 8;     // covers the input register plus queue
	localparam int unsigned RANDOM_TAGS   = 800;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	typedef enum {RX_OPEN, RX_COIN, RX_MASK, RX_TRICKLE} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;   // tag_byte[7:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;        // run_x, run_y, run_z, run_length, run_tag
	logic        m_axis_tlast;        // last_result

	run_ledger   ledger;

	// sender and receiver pacing
	bit          steady = 1'b0;       // no gaps, no stalls
	int          taken_tags = 0;      // bytes accepted at the input, dropped ones included
	rx_mode_t    rx_mode = RX_OPEN;
	int          rx_left = 0;
	int          rx_pos = 0;
	logic [15:0] rx_mask = '1;

	// tag stream shaping: runs drawn from a small palette, plus noise
	logic [7:0]  palette [3];
	int          run_left = 0;
	int          pick = 0;
	bit          noisy_phase = 1'b0;

	block_bounded_run_length_encoder_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	// receiver backpressure, switching between a few patterns
	always @(posedge clk) begin
		if (steady) begin
			m_axis_tready <= 1'b1;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(8, 80);
				rx_mask = 16'($urandom);
			end
			rx_left--;
			rx_pos = (rx_pos + 1) % 16;
			case (rx_mode)
				RX_OPEN: begin
					m_axis_tready <= 1'b1;
				end
				RX_COIN: begin
					m_axis_tready <= 1'($urandom_range(0, 1));
				end
				RX_MASK: begin
					m_axis_tready <= rx_mask[rx_pos];
				end
				default: begin
					m_axis_tready <= ($urandom_range(0, 3) == 0);
				end
			endcase
		end
	end

	// every result that moves is checked against the oldest predicted run
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			ledger.check_run(m_axis_tdata, m_axis_tlast);
	end

	function logic [7:0] next_tag();
		if (noisy_phase || $urandom_range(0, 15) == 0)
			return 8'($urandom);
		if (run_left == 0) begin
			pick     = $urandom_range(0, 2);
			run_left = $urandom_range(1, 9);
		end
		run_left--;
		return palette[pick];
	endfunction

	// one write, then cfg_valid is dropped
	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		ledger.configure(idx, value);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task send_tag(logic [7:0] tag);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= tag;
		do
			@(posedge clk);
		while (!s_axis_tready);
		void'(ledger.note_tag(tag));
		taken_tags++;
	endtask

	// stop sending until all predicted runs are out and the pipe is empty
	task drain();
		s_axis_tvalid <= 1'b0;
		while (ledger.expected_runs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// unless steady: bursts of requests with random gaps, now and then a full drain
	task stream_tags(int count);
		int burst_left;
		int gap;
		burst_left = 0;
		for (int i = 0; i < count; i++) begin
			if (!steady && burst_left == 0) begin
				burst_left = $urandom_range(1, 20);
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				if ($urandom_range(0, 30) == 0) begin
					drain();
				end else if (gap > 0) begin
					s_axis_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			send_tag(next_tag());
		end
	endtask

	task random_settings();
		logic [15:0] rw;
		logic [15:0] value;
		int          kind;
		kind = $urandom_range(0, 9);
		rw = (kind == 0) ? 16'd0 : (kind == 1) ? 16'd1 : (kind == 2) ? 16'hFFFF :
			16'($urandom_range(2, 24));
		if ($urandom_range(0, 1))
			write_reg(CFG_ROW_WIDTH, rw);
		if ($urandom_range(0, 1)) begin
			kind = $urandom_range(0, 9);
			value = (kind == 0) ? 16'd0 : (kind == 1) ? 16'd1 : (kind == 2) ? 16'hFFFF :
				(kind == 3) ? ledger.row_width : 16'($urandom_range(2, 12));
			write_reg(CFG_BLOCK_WIDTH, value);
		end
		if ($urandom_range(0, 1)) begin
			kind = $urandom_range(0, 3);
			write_reg(CFG_LAYER_Z,
				(kind == 0) ? 16'hFFFF : (kind == 1) ? 16'd0 : 16'($urandom));
		end
		if ($urandom_range(0, 1)) begin
			kind = $urandom_range(0, 3);
			write_reg(CFG_FIRST_ROW,
				(kind == 0) ? 16'hFFFF : (kind == 1) ? 16'd0 : 16'($urandom));
		end
		// keep rows coming, with the odd phase where every byte is dropped
		kind = $urandom_range(0, 11);
		value = (kind == 0) ? ledger.rows_done : (kind == 1) ? 16'hFFFF :
			16'(ledger.rows_done + $urandom_range(1, 20));
		write_reg(CFG_ROW_COUNT, value);
		foreach (palette[i])
			palette[i] = ($urandom_range(0, 5) == 0) ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom);
		noisy_phase = ($urandom_range(0, 4) == 0);
	endtask

	// opening sequence: 6-byte rows in blocks of 4, y wraps past 0xffff, then
	// rows run out and the last bytes are dropped
	localparam logic [7:0] OPENING_TAGS [20] = '{
		8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
		8'hAA, 8'h55, 8'h55, 8'h55, 8'h55, 8'hAA,
		8'h80, 8'h80, 8'h01, 8'h02, 8'h04, 8'h08,
		8'h7F, 8'hFE
	};

	initial begin
		int start_count;
		int waited;
		ledger = new();
		foreach (palette[i])
			palette[i] = 8'($urandom);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(CFG_ROW_WIDTH, 16'd6);
		write_reg(CFG_BLOCK_WIDTH, 16'd4);
		write_reg(CFG_LAYER_Z, 16'hFFFF);
		write_reg(CFG_FIRST_ROW, 16'hFFFE);
		write_reg(CFG_ROW_COUNT, 16'd3);
		write_reg(CFG_UNUSED, 16'($urandom));   // unknown index must change nothing
		foreach (OPENING_TAGS[i])
			send_tag(OPENING_TAGS[i]);
		drain();

		// zero row width acts as one: every byte is a row of its own
		write_reg(CFG_ROW_WIDTH, 16'd0);
		write_reg(CFG_ROW_COUNT, 16'd5);
		send_tag(8'hFF);
		send_tag(8'h00);
		drain();

		// zero row count drops everything
		write_reg(CFG_ROW_COUNT, 16'd0);
		send_tag(8'h3C);
		drain();

		// random rounds, now and then one with no gaps and no stalls
		start_count = taken_tags;
		while (taken_tags - start_count < RANDOM_TAGS) begin
			random_settings();
			steady = ($urandom_range(0, 7) == 0);
			stream_tags($urandom_range(4, 48));
			drain();
			steady = 1'b0;
		end

		waited = 0;
		while (ledger.expected_runs.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (ledger.expected_runs.size() != 0)
			ledger.report_mismatch($sformatf("%0d runs never arrived",
				ledger.expected_runs.size()));

		if (ledger.mismatches == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("tb: done, errors");
		$finish;
	end

endmodule
